FILE: hw/rtl/ssd_pkg.sv
// ssd_pkg: shared types, constants and the segment table for the
// seven-segment two-wire display driver. No dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int COND_TICKS  = 4;
	localparam int BYTE_TICKS  = 26;
	localparam int BIT_TICKS   = 24;
	localparam int FRAME_ITEMS = 8 + DIGIT_COUNT;

	localparam int ELEM_W = $clog2(FRAME_ITEMS);
	localparam int OFF_W  = $clog2(BYTE_TICKS);
	localparam int IDX_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// frame element positions
	localparam logic [ELEM_W-1:0] EL_BRIGHT = ELEM_W'(1);
	localparam logic [ELEM_W-1:0] EL_ADDR   = ELEM_W'(3);
	localparam logic [ELEM_W-1:0] EL_POS    = ELEM_W'(6);
	localparam logic [ELEM_W-1:0] EL_LAST   = ELEM_W'(FRAME_ITEMS - 1);

	localparam logic [7:0] CMD_DATA = 8'h40;
	localparam logic [7:0] CMD_ADDR = 8'hc0;
	localparam logic [7:0] DOT_MASK = 8'h80;

	typedef logic [DIGIT_COUNT-1:0][7:0] seg_arr_t;

	typedef enum logic [1:0] {
		EK_START,
		EK_STOP,
		EK_BYTE
	} elem_kind_t;

	function automatic elem_kind_t elem_kind(input logic [ELEM_W-1:0] e);
		if (e == ELEM_W'(0) || e == ELEM_W'(2) || e == ELEM_W'(5))
			return EK_START;
		if (e == ELEM_W'(4) || 32'(e) >= 7 + DIGIT_COUNT)
			return EK_STOP;
		return EK_BYTE;
	endfunction

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

FILE: hw/rtl/ssd_digit_enc.sv
// ssd_digit_enc: splits a 16-bit value into decimal digits, one digit per
// cycle (divide by ten via reciprocal multiply), and stores segment bytes.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_digit_enc import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] value,
	input  logic [2:0]  dot,
	output seg_arr_t    seg
);

	logic [15:0]      val_q;
	logic [2:0]       dot_q;
	logic [IDX_W-1:0] idx_q;
	logic             run_q;
	seg_arr_t         seg_q;

	logic [31:0] prod;
	logic [15:0] quo;
	logic [16:0] rem_w;
	logic [7:0]  code;

	always_comb begin
		prod  = 32'(val_q) * 32'd52429;
		quo   = 16'(prod[31:19]);
		rem_w = 17'(val_q) - ((17'(quo) << 3) + (17'(quo) << 1));
		code  = seg_code(rem_w[3:0]);
		if (32'(dot_q) == 32'(idx_q))
			code = code | DOT_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			dot_q <= '0;
			run_q <= 1'b0;
			idx_q <= '0;
			seg_q <= '0;
		end else if (start) begin
			val_q <= value;
			dot_q <= dot;
			idx_q <= '0;
			run_q <= 1'b1;
		end else if (run_q) begin
			seg_q[idx_q] <= code;
			val_q        <= quo;
			idx_q        <= idx_q + IDX_W'(1);
			if (32'(idx_q) == DIGIT_COUNT - 1)
				run_q <= 1'b0;
		end
	end

	assign seg = seg_q;

endmodule

FILE: hw/rtl/seven_segment_two_wire_display_driver_unit.sv
// seven_segment_two_wire_display_driver_unit: takes display requests and
// timing ticks, drives the clock and data pin levels of a two-wire frame.
// Each accepted word yields a registered result word; one word per cycle
// unless m_tready stalls. Digits are converted in the background after a
// request, long before the frame reaches them. Reset (arst_n, async, low)
// sets both pins high, idle, brightness 8'h8f, no result pending.
`timescale 1ns / 1ps

module seven_segment_two_wire_display_driver_unit import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // value[15:0], dot[18:16], zero
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // clk_level, dio_level, busy_res, accepted, zero
);

	logic [7:0]        bright_q;
	logic              clk_pin_q, dio_pin_q, sending_q;
	logic [ELEM_W-1:0] elem_q;
	logic [OFF_W-1:0]  off_q;
	logic [2:0]        bit_q;
	logic [1:0]        sub_q;
	logic              m_valid_q;
	logic [7:0]        m_data_q;

	seg_arr_t seg;
	logic     acc, start;

	logic              clk_n, dio_n, send_n, acc_n;
	logic [ELEM_W-1:0] elem_n, didx_w;
	logic [OFF_W-1:0]  off_n;
	logic [2:0]        bit_n;
	logic [1:0]        sub_n;
	logic [7:0]        cur_byte;
	elem_kind_t        kind;
	logic              last_off;

	assign s_tready = !m_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign start    = acc && !s_tuser && !sending_q;

	ssd_digit_enc u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (s_tdata[15:0]),
		.dot    (s_tdata[18:16]),
		.seg    (seg)
	);

	always_comb begin
		kind   = elem_kind(elem_q);
		didx_w = ELEM_W'(DIGIT_COUNT + 6) - elem_q;
		if (elem_q == EL_BRIGHT)
			cur_byte = bright_q;
		else if (elem_q == EL_ADDR)
			cur_byte = CMD_DATA;
		else if (elem_q == EL_POS)
			cur_byte = CMD_ADDR;
		else if (32'(didx_w) < DIGIT_COUNT)
			cur_byte = seg[didx_w[IDX_W-1:0]];
		else
			cur_byte = 8'h00;

		clk_n  = clk_pin_q;
		dio_n  = dio_pin_q;
		send_n = sending_q;
		acc_n  = 1'b0;
		elem_n = elem_q;
		off_n  = off_q;
		bit_n  = bit_q;
		sub_n  = sub_q;
		last_off = 1'b0;

		if (start) begin
			send_n = 1'b1;
			acc_n  = 1'b1;
			elem_n = '0;
			off_n  = '0;
			bit_n  = '0;
			sub_n  = '0;
		end else if (acc && s_tuser && sending_q) begin
			case (kind)
				EK_START: begin
					case (off_q[1:0])
						2'd0:    clk_n = 1'b1;
						2'd1:    dio_n = 1'b1;
						2'd2:    dio_n = 1'b0;
						default: clk_n = 1'b0;
					endcase
					last_off = (32'(off_q) == COND_TICKS - 1);
				end
				EK_STOP: begin
					case (off_q[1:0])
						2'd0:    clk_n = 1'b0;
						2'd1:    dio_n = 1'b0;
						2'd2:    clk_n = 1'b1;
						default: dio_n = 1'b1;
					endcase
					last_off = (32'(off_q) == COND_TICKS - 1);
				end
				default: begin
					if (32'(off_q) < BIT_TICKS) begin
						case (sub_q)
							2'd0:    clk_n = 1'b0;
							2'd1:    dio_n = cur_byte[bit_q];
							default: clk_n = 1'b1;
						endcase
						if (sub_q == 2'd2) begin
							sub_n = 2'd0;
							bit_n = bit_q + 3'd1;
						end else begin
							sub_n = sub_q + 2'd1;
						end
					end else begin
						// ack clock, data pin held
						clk_n = (32'(off_q) != BIT_TICKS);
					end
					last_off = (32'(off_q) == BYTE_TICKS - 1);
				end
			endcase
			off_n = off_q + OFF_W'(1);
			if (last_off) begin
				off_n = '0;
				bit_n = '0;
				sub_n = '0;
				elem_n = elem_q + ELEM_W'(1);
				if (elem_q == EL_LAST) begin
					elem_n = '0;
					send_n = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q  <= 8'd143;
			clk_pin_q <= 1'b1;
			dio_pin_q <= 1'b1;
			sending_q <= 1'b0;
			elem_q    <= '0;
			off_q     <= '0;
			bit_q     <= '0;
			sub_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				bright_q <= cfg_data;
			clk_pin_q <= clk_n;
			dio_pin_q <= dio_n;
			sending_q <= send_n;
			elem_q    <= elem_n;
			off_q     <= off_n;
			bit_q     <= bit_n;
			sub_q     <= sub_n;
			if (acc)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			m_data_q <= {4'b0000, acc_n, send_n, dio_n, clk_n};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
